// File: rtl/core/md5_pkg.sv
`default_nettype none

package md5_pkg;

  localparam int LENGTH_BITS = 64;
  localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic start;
    logic init;
  } cmp_ctrl_t;

  // block word used by a given round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    unique case (rnd[5:4])
      2'd0: g = r;
      2'd1: g = 4'(r * 4'd5 + 4'd1);
      2'd2: g = 4'(r * 4'd3 + 4'd5);
      default: g = 4'(r * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} << s;
    return d[63:32];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/md5_compress.sv
`default_nettype none

module md5_compress (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire md5_pkg::cmp_ctrl_t ctrl,
  input  wire logic [31:0]       rd_data,
  output logic [3:0]             rd_addr,
  output logic                   done,
  output logic [127:0]           chain
);
  import md5_pkg::*;

  logic        running;
  logic        fin;
  logic [5:0]  rnd;
  logic [31:0] ra, rb, rc, rd;
  logic [31:0] ca, cb, cc, cd;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] b_next;

  // buffer word for the next round is addressed ahead, so the registered read data is ready when that round runs
  assign rd_addr = running ? msg_index(rnd + 6'd1) : 4'd0;
  assign done    = fin;
  assign chain   = {cd, cc, cb, ca};

  always_comb begin
    unique case (rnd[5:4])
      2'd0: f = (rb & rc) | (~rb & rd);
      2'd1: f = (rd & rb) | (~rd & rc);
      2'd2: f = rb ^ rc ^ rd;
      default: f = rc ^ (rb | ~rd);
    endcase
    sum    = ra + f + SINE_K[rnd] + rd_data;
    b_next = rb + rotl32(sum, ROT_S[{rnd[5:4], rnd[1:0]}]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      rnd     <= '0;
      ca      <= IV_A;
      cb      <= IV_B;
      cc      <= IV_C;
      cd      <= IV_D;
    end else begin
      fin <= running && (rnd == 6'd63);
      if (ctrl.start) begin
        running <= 1'b1;
        rnd     <= '0;
      end else if (running) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) running <= 1'b0;
      end
      if (ctrl.init) begin
        ca <= IV_A;
        cb <= IV_B;
        cc <= IV_C;
        cd <= IV_D;
      end else if (fin) begin
        ca <= ca + ra;
        cb <= cb + rb;
        cc <= cc + rc;
        cd <= cd + rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      ra <= ca;
      rb <= cb;
      rc <= cc;
      rd <= cd;
    end else if (running) begin
      ra <= rd;
      rd <= rc;
      rc <= rb;
      rb <= b_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/md5_message_digest_unit.sv
// md5 digest of a byte stream.
// input beats on s_*: tdata holds a little-endian word and a byte count
// (0..4, above 4 counts as 4), tlast marks the final beat of a message.
// bytes pack back to back into a 16-word buffer ram even after short beats.
// s_tready is high only while the unit waits for input; there it takes
// beats back to back. each full 64-byte block runs 64 rounds, one per
// cycle, through a single round unit fed by the buffer ram's read port;
// no beat is taken while a block compresses.
// after a tlast beat the unit writes the 0x80 byte, zero words and the
// 64-bit bit length into the buffer (one word per cycle, pausing while a
// full block compresses), compresses once or twice, and presents the
// 16-byte digest on m_* as one beat. digest byte 0 sits in m_tdata[7:0].
// the digest sits in an output register; if the receiver stalls, the unit
// still accepts the next message and only waits when a second digest is
// ready before the first is taken.
// reset (synchronous, active high) restores the initial chaining values,
// clears the length and fill count, and drops m_tvalid.
`default_nettype none

module md5_message_digest_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [39:0]  s_tdata,   // data_word [31:0], byte_count [34:32], zero
  input  wire logic         s_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata    // digest_low [63:0], digest_high [127:64]
);
  import md5_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD    = 3'd1;
  localparam logic [2:0] S_ZERO   = 3'd2;
  localparam logic [2:0] S_LEN_LO = 3'd3;
  localparam logic [2:0] S_LEN_HI = 3'd4;
  localparam logic [2:0] S_CMP    = 3'd5;
  localparam logic [2:0] S_FINAL  = 3'd6;

  localparam logic [3:0] LAST_WORD    = 4'd15;
  localparam logic [3:0] LEN_WORD_LO  = 4'd14;
  localparam logic [3:0] PRE_LEN_WORD = 4'd13;

  logic [2:0]   state, state_next;
  logic [2:0]   ret;
  logic [3:0]   zptr;
  logic [5:0]   fill;
  logic [31:0]  acc;
  logic [63:0]  length;

  logic [31:0]  mem [16];
  logic [3:0]   rd_addr;
  logic [31:0]  rd_data;
  logic         wr_en;
  logic [3:0]   wr_addr;
  logic [31:0]  wr_data;

  cmp_ctrl_t    cmp_ctrl;
  logic         cmp_done;
  logic [127:0] chain;

  logic         accept;
  logic         out_free;
  logic [2:0]   cnt;
  logic [4:0]   sh;
  logic [31:0]  keep32;
  logic [63:0]  merged;
  logic [2:0]   total;
  logic [6:0]   fill_sum;
  logic [31:0]  pad_word;
  logic [63:0]  len_bits;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cnt      = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
    sh       = {fill[1:0], 3'b000};
    keep32   = (32'd1 << sh) - 32'd1;
    merged   = {32'd0, acc & keep32} | ({32'd0, s_tdata[31:0]} << sh);
    total    = {1'b0, fill[1:0]} + cnt;
    fill_sum = {1'b0, fill} + {4'd0, cnt};
    pad_word = (acc & keep32) | (32'h0000_0080 << sh);
    len_bits = length & LEN_MASK;
  end

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = fill[5:2];
    wr_data    = merged[31:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          wr_en = total[2];
          if (fill_sum[6]) state_next = S_CMP;
          else if (s_tlast) state_next = S_PAD;
        end
      end
      S_PAD: begin
        wr_en   = 1'b1;
        wr_data = pad_word;
        if (fill[5:2] == LAST_WORD) state_next = S_CMP;
        else if (fill[5:2] == PRE_LEN_WORD) state_next = S_LEN_LO;
        else state_next = S_ZERO;
      end
      S_ZERO: begin
        wr_en   = 1'b1;
        wr_addr = zptr;
        wr_data = '0;
        if (zptr == LAST_WORD) state_next = S_CMP;
        else if (zptr == PRE_LEN_WORD) state_next = S_LEN_LO;
      end
      S_LEN_LO: begin
        wr_en      = 1'b1;
        wr_addr    = LEN_WORD_LO;
        wr_data    = len_bits[31:0];
        state_next = S_LEN_HI;
      end
      S_LEN_HI: begin
        wr_en      = 1'b1;
        wr_addr    = LAST_WORD;
        wr_data    = len_bits[63:32];
        state_next = S_CMP;
      end
      S_CMP: begin
        if (cmp_done) state_next = ret;
      end
      S_FINAL: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cmp_ctrl.start = (state_next == S_CMP) && (state != S_CMP);
  assign cmp_ctrl.init  = (state == S_FINAL) && out_free;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      zptr     <= '0;
      fill     <= '0;
      length   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fill   <= fill_sum[5:0];
            length <= length + {58'd0, cnt, 3'b000};
            ret    <= s_tlast ? S_PAD : S_IDLE;
          end
        end
        S_PAD: begin
          zptr <= fill[5:2] + 4'd1;
          ret  <= S_ZERO;
        end
        S_ZERO: zptr <= zptr + 4'd1;
        S_LEN_HI: ret <= S_FINAL;
        S_FINAL: begin
          if (out_free) begin
            fill   <= '0;
            length <= '0;
          end
        end
        default: ;
      endcase
      if (cmp_ctrl.init) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) acc <= total[2] ? merged[63:32] : merged[31:0];
    if (cmp_ctrl.init) m_tdata <= chain;
  end

  md5_compress u_compress (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cmp_ctrl),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .done    (cmp_done),
    .chain   (chain)
  );

  // a block starts only after its last word is written, never word 0 in the same cycle
  a_start_write: assert property (@(posedge clk) disable iff (rst)
    (cmp_ctrl.start && wr_en) |-> (wr_addr == LAST_WORD))
    else $error("compression started while a word other than the last was written");

  a_done_in_cmp: assert property (@(posedge clk) disable iff (rst)
    cmp_done |-> (state == S_CMP))
    else $error("compression finished outside the compress state");

  a_out_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_FINAL))
    else $error("digest presented without a finished message");

  a_clear_after_digest: assert property (@(posedge clk) disable iff (rst)
    cmp_ctrl.init |=> (fill == 6'd0 && length == 64'd0 && state == S_IDLE))
    else $error("message state not cleared after digest");

endmodule

`default_nettype wire

// File: tb/sv/tb_md5_message_digest_unit.sv
`timescale 1ns / 100ps

module tb_md5_message_digest_unit;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 200;
  localparam logic [63:0] BIT_LEN_MASK = {64{1'b1}} >> (64 - md5_pkg::LENGTH_BITS);

  localparam logic [31:0] INIT_CHAIN [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ROUND_SHIFT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  typedef struct {
    logic [63:0] low;
    logic [63:0] high;
  } digest_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [39:0]  s_tdata;   // data_word [31:0], byte_count [34:32], zero
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // digest_low [63:0], digest_high [127:64]

  md5_message_digest_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // digest predictor state
  logic [31:0] chain_st [4];
  logic [31:0] blk_words [16];
  logic [5:0]  fill_cnt;
  logic [63:0] msg_bits;

  digest_t pending_digests [$];
  int      errors;
  int      items_sent;
  bit      tx_idle_en;
  bit      rx_idle_en;
  int      rx_hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void md5_reset_chain();
    for (int i = 0; i < 4; i++) chain_st[i] = INIT_CHAIN[i];
    fill_cnt = '0;
    msg_bits = '0;
  endfunction

  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int g;
    int s;
    a = chain_st[0];
    b = chain_st[1];
    c = chain_st[2];
    d = chain_st[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d);
        g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c);
        g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d;
        g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d);
        g = (7 * i) % 16;
      end
      s = ROUND_SHIFT[(i / 16) * 4 + i % 4];
      t = a + f + ROUND_K[i] + blk_words[g];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    chain_st[0] = chain_st[0] + a;
    chain_st[1] = chain_st[1] + b;
    chain_st[2] = chain_st[2] + c;
    chain_st[3] = chain_st[3] + d;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    blk_words[fill_cnt[5:2]][8 * fill_cnt[1:0] +: 8] = v;
    fill_cnt = fill_cnt + 6'd1;
    if (fill_cnt == 6'd0) md5_compress();
  endfunction

  // returns 1 when the beat closes a message, with its digest in dg
  function automatic bit absorb_beat(input logic [31:0] word, input logic [2:0] cnt,
                                     input logic fin, output digest_t dg);
    int n;
    logic [63:0] bits;
    n = (cnt > 3'd4) ? 4 : int'(cnt);
    dg.low = '0;
    dg.high = '0;
    for (int i = 0; i < n; i++) begin
      absorb_byte(word[8 * i +: 8]);
      msg_bits = msg_bits + 64'd8;
    end
    if (!fin) return 1'b0;
    bits = msg_bits & BIT_LEN_MASK;
    absorb_byte(8'h80);
    while (fill_cnt != 6'd56) absorb_byte(8'h00);
    blk_words[14] = bits[31:0];
    blk_words[15] = bits[63:32];
    md5_compress();
    dg.low = {chain_st[1], chain_st[0]};
    dg.high = {chain_st[3], chain_st[2]};
    md5_reset_chain();
    return 1'b1;
  endfunction

  task automatic send_beat(input logic [31:0] word, input logic [2:0] cnt, input logic fin);
    digest_t dg;
    while (tx_idle_en && $urandom_range(99) < 12) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, cnt, word};
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (absorb_beat(word, cnt, fin, dg)) pending_digests.push_back(dg);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_word();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'hffffffff;
    if (r < 10) return 32'h00000000;
    return $urandom;
  endfunction

  // mostly full words, some short or over-wide counts in the body
  task automatic send_random_message(input int n_body, input bit fin);
    int r;
    logic [2:0] cnt;
    for (int k = 0; k < n_body; k++) begin
      r = $urandom_range(99);
      if (r < 8) cnt = 3'($urandom_range(0, 3));
      else if (r < 11) cnt = 3'($urandom_range(5, 7));
      else cnt = 3'd4;
      send_beat(random_word(), cnt, 1'b0);
    end
    if (fin) send_beat(random_word(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  function automatic int pick_body_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(0, 20);
    if (r < 95) return $urandom_range(20, 40);
    return $urandom_range(60, 130);
  endfunction

  task automatic wait_for_digests();
    while (pending_digests.size() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed_vectors();
    send_beat(32'h00000000, 3'd0, 1'b1);          // empty message
    send_beat(32'h00636261, 3'd3, 1'b1);          // "abc"
    send_beat(32'hffffffff, 3'd7, 1'b1);          // count above four
    send_beat(32'h00000000, 3'd5, 1'b0);
    send_beat(32'ha5a5a5a5, 3'd6, 1'b1);
    // short beats inside a message pack back to back
    send_beat(32'h11223344, 3'd1, 1'b0);
    send_beat(32'h55667788, 3'd2, 1'b0);
    send_beat(32'hdeadbeef, 3'd4, 1'b0);
    send_beat(32'hcafef00d, 3'd3, 1'b1);
    send_beat(32'hffffffff, 3'd0, 1'b0);
    send_beat(32'h12345678, 3'd4, 1'b0);
    send_beat(32'hffffffff, 3'd0, 1'b1);          // last beat with no bytes
    // 56 bytes: padding spills into a second block
    for (int k = 0; k < 13; k++) send_beat(32'hffffffff, 3'd4, 1'b0);
    send_beat(32'h00000000, 3'd4, 1'b1);
  endtask

  task automatic test_random_messages(input int n_beats);
    int target;
    target = items_sent + n_beats;
    while (items_sent < target) send_random_message(pick_body_len(), 1'b1);
  endtask

  task automatic test_steady_stream(input int n_beats);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_messages(n_beats);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // receiver stalls while one-beat messages keep coming, so the unit fills up
  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    rx_hold_left = HOLD_CYCLES;
    for (int k = 0; k < 12; k++) send_beat(random_word(), 3'($urandom_range(0, 4)), 1'b1);
    for (int k = 0; k < 6; k++) send_random_message($urandom_range(1, 18), 1'b1);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 3; k++) send_random_message(pick_body_len(), 1'b1);
      s_tvalid <= 1'b0;
      wait_for_digests();
    end
  endtask

  // message never marked last: no digest may appear
  task automatic test_unterminated_tail();
    send_random_message(20, 1'b0);
    s_tvalid <= 1'b0;
  endtask

  // receiver ready pattern, with a counted hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left = rx_hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !rx_idle_en || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    digest_t exp_dg;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_digests.size() == 0) begin
        errors++;
        $display("%0t unexpected digest: expected none actual %h", $time, m_tdata);
      end else begin
        exp_dg = pending_digests.pop_front();
        if (m_tdata[63:0] !== exp_dg.low) begin
          errors++;
          $display("%0t digest_low mismatch: expected %h actual %h",
                   $time, exp_dg.low, m_tdata[63:0]);
        end
        if (m_tdata[127:64] !== exp_dg.high) begin
          errors++;
          $display("%0t digest_high mismatch: expected %h actual %h",
                   $time, exp_dg.high, m_tdata[127:64]);
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("md5_message_digest_unit verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    errors = 0;
    items_sent = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rx_hold_left = 0;
    for (int i = 0; i < 16; i++) blk_words[i] = '0;
    md5_reset_chain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_vectors();
    test_random_messages(700);
    test_steady_stream(300);
    test_output_backpressure();
    test_drain_pause();
    test_random_messages(300);
    test_unterminated_tail();

    wait_for_digests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_digests.size() > 0) begin
      errors++;
      $display("%0t missing digests: expected %0d more actual 0",
               $time, pending_digests.size());
    end
    if (errors == 0) begin
      $display("md5_message_digest_unit verification clean");
    end else begin
      $display("md5_message_digest_unit verification failed");
    end
    $finish;
  end

endmodule
